@@ rtl/trial_division_prime_table_top_macros.svh @@
// Assertion helpers for the prime table block.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef TRIAL_DIVISION_PRIME_TABLE_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDPT_ASSERT_NOW(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDPT_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

@@ rtl/tdpt_pkg.sv @@
package tdpt_pkg;

  // Width of the primes_held result field.
  localparam int PRIMES_HELD_W = 13;

  // Prime counted as table entry 0 from reset onwards; that entry is never written.
  localparam int FIRST_PRIME = 2;

  // Sequencer state vector.
  typedef logic [2:0] state_t;

endpackage

@@ rtl/trial_division_prime_table_top.sv @@
// Trial-division prime test against a table of primes found so far.
//
// Input channel (in_valid / in_ready / in_candidate): one candidate per
// transfer. Result channel (out_valid / out_ready / out_*): one result per
// candidate, in order: found_prime, was_stored, table_full and primes_held.
//
// Sequence: each entry above entry 0 that is tried costs a table read, a
// compare and, unless the walk stops there, NUMBER_WIDTH restoring remainder
// steps. The walk stops at the first entry not below half the candidate,
// rounded down. Zero, one, two, even candidates and odd ones with only entry 0
// held go from the check straight to the finish state.
// Throughput: one candidate at a time; in_ready is high only while the
// sequencer is idle, and the next transfer may share an edge with the result.
//
// Reset clears the table count to one; entry 0 is the prime two and is
// tested as the low bit of the candidate, so no clearing pass is needed.
// Entries above the count are never read.
//
// A stalled receiver holds the result in the output register and the next
// result in the sequencer; the table is only updated once it can be loaded.
`include "trial_division_prime_table_top_macros.svh"

module trial_division_prime_table_top
  import tdpt_pkg::*;
#(
  parameter int TABLE_DEPTH  = 4096,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_candidate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found_prime,
  output logic                     out_was_stored,
  output logic                     out_table_full,
  output logic [PRIMES_HELD_W-1:0] out_primes_held
);

  localparam int W  = NUMBER_WIDTH;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int BW = $clog2(NUMBER_WIDTH);

  localparam logic [W-1:0]  TWO       = W'(FIRST_PRIME);
  localparam logic [CW-1:0] COUNT_ONE = CW'(1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_DEPTH);

  // Sequencer states
  localparam state_t S_IDLE  = 3'd0;
  localparam state_t S_CHECK = 3'd1;
  localparam state_t S_READ  = 3'd2;
  localparam state_t S_CMP   = 3'd3;
  localparam state_t S_DIV   = 3'd4;
  localparam state_t S_FIN   = 3'd5;

  state_t         state_r;
  logic [W-1:0]   n_r;        // candidate under test
  logic [CW-1:0]  i_r;        // table index being tried
  logic [CW-1:0]  count_r;    // primes held
  logic [CW-1:0]  count_nxt;
  logic [W-1:0]   rem_r;      // partial remainder
  logic [W-1:0]   quo_r;      // dividend bits still to shift in
  logic [BW-1:0]  bit_r;      // bits left in this division
  logic           prime_r;

  // Prime table: one write port, one registered read port
  logic [W-1:0]   mem [TABLE_DEPTH];
  logic [W-1:0]   rd_data_r;
  logic           mem_we;
  logic           mem_re;

  logic           out_valid_r;
  logic           out_found_prime_r;
  logic           out_was_stored_r;
  logic           out_table_full_r;
  logic [PRIMES_HELD_W-1:0] out_primes_held_r;

  logic [63:0]    cand_wide;
  logic [W-1:0]   cand_n;
  logic [W-1:0]   half;
  logic [W:0]     rem_sh;
  logic [W:0]     divisor_x;
  logic [W-1:0]   rem_new;
  logic           fin_go;
  logic           table_is_full;
  logic           store;
  logic [CW-1:0]  i_inc;
  logic [31:0]    count_wide;

  // Take the candidate modulo 2^NUMBER_WIDTH
  assign cand_wide = 64'(in_candidate);
  assign cand_n    = cand_wide[W-1:0];
  assign half      = n_r >> 1;

  // One restoring remainder step
  assign rem_sh    = {rem_r, quo_r[W-1]};
  assign divisor_x = {1'b0, rd_data_r};
  assign rem_new   = (rem_sh >= divisor_x) ? W'(rem_sh - divisor_x) : rem_sh[W-1:0];

  assign i_inc = i_r + COUNT_ONE;

  // Finish only when the output register can take the result
  assign fin_go        = !out_valid_r || out_ready;
  assign table_is_full = (count_r == COUNT_MAX);
  assign store         = prime_r && (n_r != TWO) && !table_is_full;
  assign mem_we        = (state_r == S_FIN) && fin_go && store;
  assign mem_re        = (state_r == S_READ);
  assign count_nxt     = count_r + CW'(store);
  assign count_wide    = 32'(count_nxt);

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= n_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[i_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= COUNT_ONE;
      i_r     <= COUNT_ONE;
      prime_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r     <= cand_n;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Zero, one, two and even candidates need no table walk
          if (n_r < TWO) begin
            prime_r <= 1'b0;
            state_r <= S_FIN;
          end else if (n_r == TWO) begin
            prime_r <= 1'b1;
            state_r <= S_FIN;
          end else if (!n_r[0]) begin
            prime_r <= 1'b0;
            state_r <= S_FIN;
          end else if (count_r > COUNT_ONE) begin
            i_r     <= COUNT_ONE;
            state_r <= S_READ;
          end else begin
            prime_r <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Stop the walk at the first entry not below half the candidate, rounded down
          if (rd_data_r >= half) begin
            prime_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            rem_r   <= '0;
            quo_r   <= n_r;
            bit_r   <= BW'(W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_new;
          quo_r <= {quo_r[W-2:0], 1'b0};
          if (bit_r == '0) begin
            if (rem_new == '0) begin
              prime_r <= 1'b0;
              state_r <= S_FIN;
            end else if (i_inc < count_r) begin
              i_r     <= i_inc;
              state_r <= S_READ;
            end else begin
              prime_r <= 1'b1;
              state_r <= S_FIN;
            end
          end else begin
            bit_r <= bit_r - BW'(1);
          end
        end
        S_FIN: begin
          if (fin_go) begin
            count_r <= count_nxt;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && fin_go) begin
      out_found_prime_r <= prime_r;
      out_was_stored_r  <= store;
      out_table_full_r  <= (count_nxt >= COUNT_MAX);
      out_primes_held_r <= count_wide[PRIMES_HELD_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_prime = out_found_prime_r;
  assign out_was_stored  = out_was_stored_r;
  assign out_table_full  = out_table_full_r;
  assign out_primes_held = out_primes_held_r;

  `TDPT_ASSERT_NOW(a_count_range, 1'b1,
                   (count_r >= COUNT_ONE) && (count_r <= COUNT_MAX),
                   "table count out of range")
  `TDPT_ASSERT_NOW(a_read_written, state_r == S_READ,
                   (i_r != '0) && (i_r < count_r),
                   "table read beyond the primes held")
  `TDPT_ASSERT_NEXT(a_store_counts, mem_we,
                    count_r == $past(count_r) + COUNT_ONE,
                    "store did not advance the table count")
  `TDPT_ASSERT_NOW(a_stored_is_prime, out_valid_r && out_was_stored_r,
                   out_found_prime_r && !(out_primes_held_r == '0 && CW <= PRIMES_HELD_W),
                   "stored result not reported prime")

endmodule
